### rtl/bfsl_pkg.sv
// Shared types, constants and helpers for the breadth-first search level block.
`default_nettype none

package bfsl_pkg;

   localparam int MAX_NODES  = 64;
   localparam int MAX_EDGES  = 256;
   localparam int FIFO_DEPTH = 4;

   localparam int NODE_W      = 7;
   localparam int LEVEL_W     = 6;
   localparam int NODE_IDX_W  = $clog2(MAX_NODES);
   localparam int NODE_CNT_W  = $clog2(MAX_NODES + 1);
   localparam int EDGE_ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_NODE = CSR_IDX_W'(1);

   localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(64);
   localparam logic [NODE_W-1:0] START_NODE_RESET = NODE_W'(1);

   typedef struct packed {
      logic              operation;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node_id;
      logic [LEVEL_W-1:0] hop_level;
      logic               reached;
      logic               edges_dropped;
      logic               last;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic              run;
      logic              bad;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } cmd_type;

   typedef struct packed {
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] second;
   } edge_ent_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [NODE_W-1:0]  node;
   } qent_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_FETCH,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } eng_state_type;

   // zero acts as one, anything above the node limit acts as the limit
   function automatic logic [NODE_W-1:0] active_count(input logic [NODE_W-1:0] raw);
      logic [NODE_W-1:0] res;
      if (raw == '0) begin
         res = NODE_W'(1);
      end else if (raw > NODE_W'(MAX_NODES)) begin
         res = NODE_W'(MAX_NODES);
      end else begin
         res = raw;
      end
      return res;
   endfunction

   function automatic logic node_ok(input logic [NODE_W-1:0] node,
                                    input logic [NODE_W-1:0] cnt);
      return (node != '0) && (node <= cnt);
   endfunction

   // nodes are numbered from one, storage from zero
   function automatic logic [NODE_IDX_W-1:0] node_index(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] t;
      t = node - NODE_W'(1);
      return t[NODE_IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/bfs_node_levels.sv
// Top level: configuration registers, front end, command queue and search engine.
//
// Edge requests are taken one per cycle into a four-entry command queue when not
// full, and stored by the engine one per cycle while idle. A run request searches
// from start_node: a start step, then per dequeued node a fetch and a walk of the
// single-port edge store, then a read and an output step per result for nodes 1 to
// node_count, as rsp_stall allows. Requests keep queueing while a run is busy.
// Endpoints are checked against node_count at load time; a bad or overflowing edge
// is dropped and flags every result of the next run. The edge store is emptied
// after each run. No clearing pass follows reset. csr_ready is always high; the user
// writes configuration only while the block is idle; it is not enforced.
`default_nettype none

module bfs_node_levels (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bfsl_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bfsl_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfsl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfsl_pkg::NODE_W-1:0]    csr_wdata
);
   import bfsl_pkg::*;

   logic [NODE_W-1:0] node_count_ff, node_count_in;
   logic [NODE_W-1:0] start_node_ff, start_node_in;

   logic    push, queue_full, cmd_pop, cmd_valid;
   cmd_type push_data, cmd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      node_count_in = node_count_ff;
      start_node_in = start_node_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_wdata;
            CSR_START_NODE: start_node_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         start_node_ff <= START_NODE_RESET;
      end else begin
         node_count_ff <= node_count_in;
         start_node_ff <= start_node_in;
      end
   end

   bfsl_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .node_count (node_count_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   bfsl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (cmd_data)
   );

   bfsl_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .node_count (node_count_ff),
      .start_node (start_node_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/bfsl_front.sv
// Front end: takes requests, checks edge endpoints and queues commands.
`default_nettype none

module bfsl_front (
   input  logic                        req_valid,
   input  bfsl_pkg::req_type           req_data,
   output logic                        req_stall,
   input  logic [bfsl_pkg::NODE_W-1:0] node_count,
   input  logic                        queue_full,
   output logic                        push,
   output bfsl_pkg::cmd_type           push_data
);
   import bfsl_pkg::*;

   logic [NODE_W-1:0] cnt;

   assign cnt       = active_count(node_count);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data.run    = (req_data.operation == OP_RUN);
      push_data.bad    = !node_ok(req_data.node_a, cnt) || !node_ok(req_data.node_b, cnt);
      push_data.node_a = req_data.node_a;
      push_data.node_b = req_data.node_b;
   end

endmodule

`default_nettype wire

### rtl/bfsl_queue.sv
// Short command queue between the front end and the search engine.
`default_nettype none

module bfsl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfsl_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output bfsl_pkg::cmd_type pop_data
);
   import bfsl_pkg::*;

   cmd_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign full      = (fill_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/bfsl_engine.sv
// Back end: edge store, breadth-first search and level read-out.
`default_nettype none

module bfsl_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  bfsl_pkg::cmd_type           cmd_data,
   output logic                        cmd_pop,
   input  logic [bfsl_pkg::NODE_W-1:0] node_count,
   input  logic [bfsl_pkg::NODE_W-1:0] start_node,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bfsl_pkg::rsp_type           rsp_data
);
   import bfsl_pkg::*;

   eng_state_type state_ff, state_in;

   logic [EDGE_CNT_W-1:0] edges_held_ff, edges_held_in;
   logic                  drop_ff, drop_in;
   logic [MAX_NODES-1:0]  visited_ff, visited_in;
   logic [NODE_CNT_W-1:0] head_ff, head_in;
   logic [NODE_CNT_W-1:0] tail_ff, tail_in;
   logic [NODE_W-1:0]     cur_node_ff, cur_node_in;
   logic [LEVEL_W-1:0]    cur_level_ff, cur_level_in;
   logic [EDGE_CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic                  scan_pend_ff, scan_pend_in;
   logic [NODE_W-1:0]     emit_node_ff, emit_node_in;
   logic [NODE_W-1:0]     count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // storage
   edge_ent_type       edge_mem [MAX_EDGES];
   qent_type           queue_mem [MAX_NODES];
   logic [LEVEL_W-1:0] level_mem [MAX_NODES];
   edge_ent_type       edge_rd_ff;
   qent_type           q_rd_ff;
   logic [LEVEL_W-1:0] lvl_rd_ff;

   logic                   edge_we, edge_re;
   edge_ent_type           edge_wdata;
   logic                   q_we, q_re;
   logic [NODE_IDX_W-1:0]  q_waddr;
   qent_type               q_wdata;
   logic                   lvl_we, lvl_re;
   logic [NODE_IDX_W-1:0]  lvl_waddr;
   logic [LEVEL_W-1:0]     lvl_wdata;

   logic              start_ok, scan_issue, scan_done, store_full;
   logic              e_in_range, hit_a, hit_b, do_visit, emit_last, out_free;
   logic [NODE_W-1:0] other;

   assign start_ok   = node_ok(start_node, count_ff);
   assign scan_issue = (scan_addr_ff < edges_held_ff);
   assign scan_done  = !scan_issue && !scan_pend_ff;
   assign store_full = (edges_held_ff == EDGE_CNT_W'(MAX_EDGES));
   // stale edges (endpoint above the count now in force) are skipped
   assign e_in_range = node_ok(edge_rd_ff.first, count_ff) &&
                       node_ok(edge_rd_ff.second, count_ff);
   assign hit_a      = (edge_rd_ff.first == cur_node_ff);
   assign hit_b      = (edge_rd_ff.second == cur_node_ff);
   assign other      = hit_a ? edge_rd_ff.second : edge_rd_ff.first;
   assign do_visit   = (state_ff == ST_SCAN) && scan_pend_ff && e_in_range &&
                       (hit_a || hit_b) && !visited_ff[node_index(other)] &&
                       (tail_ff < NODE_CNT_W'(MAX_NODES));
   assign emit_last  = (emit_node_ff == count_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_data.run) begin
               state_in = ST_START;
            end
         end
         ST_START:    state_in = start_ok ? ST_POP : ST_EMIT_RD;
         ST_POP:      state_in = (head_ff < tail_ff) ? ST_FETCH : ST_EMIT_RD;
         ST_FETCH:    state_in = ST_SCAN;
         ST_SCAN:     state_in = scan_done ? ST_POP : ST_SCAN;
         ST_EMIT_RD:  state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_pop       = 1'b0;
      edges_held_in = edges_held_ff;
      drop_in       = drop_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_node_in   = cur_node_ff;
      cur_level_in  = cur_level_ff;
      scan_addr_in  = scan_addr_ff;
      scan_pend_in  = scan_pend_ff;
      emit_node_in  = emit_node_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      edge_we    = 1'b0;
      edge_re    = 1'b0;
      edge_wdata.first  = cmd_data.node_a;
      edge_wdata.second = cmd_data.node_b;
      q_we       = 1'b0;
      q_re       = 1'b0;
      q_waddr    = tail_ff[NODE_IDX_W-1:0];
      q_wdata.level = cur_level_ff + LEVEL_W'(1);
      q_wdata.node  = other;
      lvl_we     = 1'b0;
      lvl_re     = 1'b0;
      lvl_waddr  = node_index(other);
      lvl_wdata  = cur_level_ff + LEVEL_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               if (cmd_data.run) begin
                  count_in   = active_count(node_count);
                  visited_in = '0;
               end else if (cmd_data.bad || store_full) begin
                  drop_in = 1'b1;
               end else begin
                  edge_we       = 1'b1;
                  edges_held_in = edges_held_ff + EDGE_CNT_W'(1);
               end
            end
         end
         ST_START: begin
            emit_node_in = NODE_W'(1);
            head_in      = '0;
            tail_in      = '0;
            if (start_ok) begin
               visited_in[node_index(start_node)] = 1'b1;
               lvl_we        = 1'b1;
               lvl_waddr     = node_index(start_node);
               lvl_wdata     = '0;
               q_we          = 1'b1;
               q_waddr       = '0;
               q_wdata.level = '0;
               q_wdata.node  = start_node;
               tail_in       = NODE_CNT_W'(1);
            end
         end
         ST_POP: begin
            if (head_ff < tail_ff) begin
               q_re    = 1'b1;
               head_in = head_ff + NODE_CNT_W'(1);
            end
         end
         ST_FETCH: begin
            cur_node_in  = q_rd_ff.node;
            cur_level_in = q_rd_ff.level;
            scan_addr_in = '0;
            scan_pend_in = 1'b0;
         end
         ST_SCAN: begin
            // read of edge e overlaps the check of edge e-1
            scan_pend_in = scan_issue;
            if (scan_issue) begin
               edge_re      = 1'b1;
               scan_addr_in = scan_addr_ff + EDGE_CNT_W'(1);
            end
            if (do_visit) begin
               visited_in[node_index(other)] = 1'b1;
               lvl_we  = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + NODE_CNT_W'(1);
            end
         end
         ST_EMIT_RD: begin
            lvl_re = 1'b1;
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.node_id       = emit_node_ff;
               rsp_data_in.reached       = visited_ff[node_index(emit_node_ff)];
               rsp_data_in.hop_level     = visited_ff[node_index(emit_node_ff)] ?
                                           lvl_rd_ff : '0;
               rsp_data_in.edges_dropped = drop_ff;
               rsp_data_in.last          = emit_last;
               if (emit_last) begin
                  edges_held_in = '0;
                  drop_in       = 1'b0;
               end else begin
                  emit_node_in = emit_node_ff + NODE_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edges_held_ff <= '0;
         drop_ff       <= 1'b0;
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         scan_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edges_held_ff <= edges_held_in;
         drop_ff       <= drop_in;
         visited_ff    <= visited_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         scan_pend_ff  <= scan_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_node_ff  <= cur_node_in;
      cur_level_ff <= cur_level_in;
      scan_addr_ff <= scan_addr_in;
      emit_node_ff <= emit_node_in;
      count_ff     <= count_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edges_held_ff[EDGE_ADDR_W-1:0]] <= edge_wdata;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[scan_addr_ff[EDGE_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (q_re) begin
         q_rd_ff <= queue_mem[head_ff[NODE_IDX_W-1:0]];
      end
   end

   // only entries of visited nodes are ever used, so no clearing
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         level_mem[lvl_waddr] <= lvl_wdata;
      end
      if (lvl_re) begin
         lvl_rd_ff <= level_mem[node_index(emit_node_ff)];
      end
   end

endmodule

`default_nettype wire

### rtl/bfsl_checker.sv
// Port-level checks for the breadth-first search level block, bound to the top level.
`default_nettype none

module bfsl_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfsl_pkg::rsp_type rsp_data
);
   import bfsl_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reached |-> rsp_data.hop_level == '0)
      else $error("unreached node with nonzero level");

   a_node_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.node_id != '0 && rsp_data.node_id <= NODE_W'(MAX_NODES))
      else $error("node id out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind bfs_node_levels bfsl_checker u_bfsl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### verif/tb_bfs_node_levels.sv
// Self-checking testbench for the breadth-first search level block.
`default_nettype none

module tb_bfs_node_levels;
   import bfsl_pkg::*;

   localparam int DRAIN_CYCLES   = 32;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 200;
   localparam int PHASE_ITEMS    = 30;

   // Predicts hop levels from the accepted requests and holds the levels still due.
   class level_scoreboard;
      logic [NODE_W-1:0] count_reg = NODE_COUNT_RESET;
      logic [NODE_W-1:0] start_reg = START_NODE_RESET;
      int                stored_a [MAX_EDGES];
      int                stored_b [MAX_EDGES];
      int                stored_total = 0;
      bit                dropped = 1'b0;
      rsp_type           levels_due [$];
      int                fail_count = 0;

      function int live_nodes();
         if (count_reg == '0) return 1;
         if (count_reg > MAX_NODES) return MAX_NODES;
         return int'(count_reg);
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [NODE_W-1:0] val);
         if (idx == CSR_NODE_COUNT) count_reg = val;
         else if (idx == CSR_START_NODE) start_reg = val;
      endfunction

      function int pending();
         return levels_due.size();
      endfunction

      function void note_request(input req_type item);
         int                 cnt;
         int                 a;
         int                 b;
         int                 cur;
         int                 start;
         int                 frontier [$];
         bit                 seen [MAX_NODES+1];
         logic [LEVEL_W-1:0] lvl [MAX_NODES+1];
         rsp_type            r;
         cnt = live_nodes();
         if (item.operation == OP_EDGE) begin
            a = int'(item.node_a);
            b = int'(item.node_b);
            if (a < 1 || a > cnt || b < 1 || b > cnt || stored_total >= MAX_EDGES) begin
               dropped = 1'b1;
            end else begin
               stored_a[stored_total] = a;
               stored_b[stored_total] = b;
               stored_total++;
            end
            return;
         end
         foreach (seen[i]) begin
            seen[i] = 1'b0;
            lvl[i]  = '0;
         end
         start = int'(start_reg);
         if (start >= 1 && start <= cnt) begin
            seen[start] = 1'b1;
            frontier = {frontier, start};
         end
         while (frontier.size() != 0) begin
            cur = frontier.pop_front();
            for (int e = 0; e < stored_total; e++) begin
               a = stored_a[e];
               b = stored_b[e];
               // edges loaded under a larger node count no longer count
               if (a > cnt || b > cnt) continue;
               if (a == cur && !seen[b]) begin
                  seen[b] = 1'b1;
                  lvl[b]  = lvl[cur] + 1'b1;
                  frontier = {frontier, b};
               end
               if (b == cur && !seen[a]) begin
                  seen[a] = 1'b1;
                  lvl[a]  = lvl[cur] + 1'b1;
                  frontier = {frontier, a};
               end
            end
         end
         for (int i = 1; i <= cnt; i++) begin
            r.node_id       = NODE_W'(i);
            r.hop_level     = lvl[i];
            r.reached       = seen[i];
            r.edges_dropped = dropped;
            r.last          = (i == cnt);
            levels_due = {levels_due, r};
         end
         stored_total = 0;
         dropped      = 1'b0;
      endfunction

      function string show(input rsp_type r);
         return $sformatf("node %0d level %0d reached %0b dropped %0b last %0b",
                          r.node_id, r.hop_level, r.reached, r.edges_dropped, r.last);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (levels_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected level result: %s", show(got));
            return;
         end
         want = levels_due.pop_front();
         if (got.node_id !== want.node_id || got.hop_level !== want.hop_level ||
             got.reached !== want.reached || got.edges_dropped !== want.edges_dropped ||
             got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
               $display("level mismatch: expected %s, got %s", show(want), show(got));
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [NODE_W-1:0]    csr_wdata = '0;

   level_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int requests_sent = 0;

   bfs_node_levels u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[bfs_node_levels] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_req(input logic op, input int a, input int b);
      req_type item;
      item.operation = op;
      item.node_a    = NODE_W'(a);
      item.node_b    = NODE_W'(b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
      requests_sent++;
   endtask

   task automatic send_run();
      send_req(OP_RUN, $urandom_range(127), $urandom_range(127));
   endtask

   // both registers in one burst so csr_valid stays high between them
   task automatic set_config(input int cnt_val, input int start_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= NODE_W'(cnt_val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(CSR_NODE_COUNT, NODE_W'(cnt_val));
      csr_index <= CSR_START_NODE;
      csr_wdata <= NODE_W'(start_val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(CSR_START_NODE, NODE_W'(start_val));
      csr_valid <= 1'b0;
   endtask

   // wait for every level, then let queued edge requests drain into the store
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_node(input int cnt);
      if ($urandom_range(9) == 0) return $urandom_range(127);
      return $urandom_range(cnt, 1);
   endfunction

   task automatic load_graph(input int cnt, input int edges);
      for (int i = 0; i < edges; i++) send_req(OP_EDGE, pick_node(cnt), pick_node(cnt));
   endtask

   // path through shuffled nodes, beginning at the start node where it is in range
   task automatic load_chain(input int cnt, input int start, input int length);
      int order [MAX_NODES];
      int k;
      int tmp;
      for (int j = 0; j < cnt; j++) order[j] = j + 1;
      for (int j = cnt - 1; j > 0; j--) begin
         k        = $urandom_range(j, 0);
         tmp      = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      for (int j = 0; j < cnt; j++) begin
         if (order[j] == start) begin
            order[j] = order[0];
            order[0] = start;
         end
      end
      for (int j = 0; j < length; j++) begin
         if ($urandom_range(1)) send_req(OP_EDGE, order[j], order[j+1]);
         else send_req(OP_EDGE, order[j+1], order[j]);
      end
   endtask

   initial begin
      int ph;
      int sel;
      int raw;
      int cnt_eff;
      int start;
      int budget;
      int target;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: chain, self loop, both extremes, bad endpoints
      send_req(OP_EDGE, 1, 2);
      send_req(OP_EDGE, 2, 3);
      send_req(OP_EDGE, 3, 3);
      send_req(OP_EDGE, 1, 64);
      send_req(OP_EDGE, 64, 63);
      send_req(OP_EDGE, 0, 5);
      send_req(OP_EDGE, 5, 65);
      send_req(OP_EDGE, 127, 127);
      send_run();
      settle();

      // start at the top node, some nodes left unreached
      set_config(5, 5);
      send_req(OP_EDGE, 1, 2);
      send_req(OP_EDGE, 2, 3);
      send_req(OP_EDGE, 4, 5);
      send_req(OP_EDGE, 5, 5);
      send_run();
      settle();

      // edges stored under a large count, run under a smaller one
      set_config(64, 1);
      send_req(OP_EDGE, 1, 3);
      send_req(OP_EDGE, 3, 40);
      send_req(OP_EDGE, 40, 41);
      settle();
      set_config(8, 1);
      send_run();
      settle();

      // zero count acts as one
      set_config(0, 1);
      send_req(OP_EDGE, 1, 1);
      send_run();
      settle();

      // count above the limit, start of zero
      set_config(127, 0);
      send_req(OP_EDGE, 1, 2);
      send_run();
      settle();

      // start above the count, empty store
      set_config(64, 127);
      send_run();
      settle();

      // overfill the edge store with good edges
      set_config(64, 1);
      for (int i = 0; i < MAX_EDGES + 4; i++)
         send_req(OP_EDGE, $urandom_range(64, 1), $urandom_range(64, 1));
      send_run();
      settle();

      target = requests_sent + RANDOM_ITEMS;
      ph = 0;
      while (requests_sent < target) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         sel = $urandom_range(9);
         if (sel < 5) raw = $urandom_range(16, 2);
         else if (sel < 7) raw = $urandom_range(64, 17);
         else begin
            case ($urandom_range(3))
               0: raw = 0;
               1: raw = 1;
               2: raw = 64;
               default: raw = $urandom_range(127, 65);
            endcase
         end
         if (ph == 3) raw = 64;
         cnt_eff = (raw == 0) ? 1 : ((raw > MAX_NODES) ? MAX_NODES : raw);
         sel = $urandom_range(9);
         if (sel < 7) start = $urandom_range(cnt_eff, 1);
         else if (sel == 7) start = 0;
         else if (sel == 8) start = cnt_eff;
         else start = $urandom_range(127, cnt_eff + 1);
         set_config(raw, start);

         if (ph == 2) hold_seq++;
         if (ph == 3) begin
            // one path through every node gives the deepest level
            load_chain(cnt_eff, start, cnt_eff - 1);
            send_run();
         end

         budget = requests_sent + PHASE_ITEMS;
         while (requests_sent < budget) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
               load_graph(cnt_eff, $urandom_range(2 * cnt_eff, 1));
               send_run();
            end else if (sel < 75 && cnt_eff >= 2) begin
               load_chain(cnt_eff, start,
                          $urandom_range(1) ? cnt_eff - 1 : $urandom_range(cnt_eff - 1, 1));
               send_run();
            end else if (sel < 88) begin
               for (int i = $urandom_range(6, 1); i > 0; i--)
                  send_req(OP_EDGE, $urandom_range(127), $urandom_range(127));
               if ($urandom_range(1)) send_run();
            end else begin
               send_run();
            end
         end
         settle();
         ph++;
      end

      if (sb.fail_count == 0 && sb.pending() == 0) $display("[bfs_node_levels] OK");
      else $display("[bfs_node_levels] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
